// ===== design/adcs_pkg.sv =====
// Shared constants, types and the NTC resistance table of the ADC sensor scaler.
`default_nettype none

package adcs_pkg;

  // Field and register widths
  localparam int ADC_BITS      = 12;
  localparam int TABLE_ENTRIES = 151;
  localparam int CMD_W         = 3;
  localparam int RAW_W         = ADC_BITS;
  localparam int VAL_W         = 16;
  localparam int VREF_W        = 13;
  localparam int FS_W          = 16;
  localparam int SUP_W         = 13;
  localparam int SER_W         = 16;
  localparam int CFG_DATA_W    = 16;

  // Serial multiply/divide unit: 2 bits per cycle
  localparam int MD_W  = 32;
  localparam int MDB_W = 16;
  localparam int DIG_W = $clog2(MD_W / 2 + 1);

  // Intermediate widths
  localparam int PROD1_W     = RAW_W + VREF_W;   // raw * vref
  localparam int MV_W        = PROD1_W;          // millivolts, full scale may be 1
  localparam int TPROD_W     = SUP_W + SER_W;    // mv * series, mv below supply
  localparam int MOTOR_NUM_W = 8;
  localparam int MPROD_W     = VAL_W + MOTOR_NUM_W;

  // Digit counts of each serial operation
  localparam int DIG_RAW = (RAW_W + 1) / 2;
  localparam int DIG_P   = (PROD1_W + 1) / 2;
  localparam int DIG_MV  = VAL_W / 2;
  localparam int DIG_T   = (TPROD_W + 1) / 2;
  localparam int DIG_M   = (MPROD_W + 1) / 2;
  localparam int DIG_V   = (MV_W + 1) / 2;

  // Table search
  localparam int IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int SRCH_STEPS = IDX_W;
  localparam int SCNT_W     = $clog2(SRCH_STEPS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Channel scaling constants
  localparam logic [MDB_W-1:0] MOTOR_NUM = 16'd133;
  localparam logic [MDB_W-1:0] MOTOR_DEN = 16'd100;
  localparam int               VALVE_NUM = 2;
  localparam int               VALVE_DEN = 10;
  localparam logic [MDB_W-1:0] VALVE_DIV = MDB_W'(VALVE_DEN / VALVE_NUM);
  localparam logic [MDB_W-1:0] VIN_GAIN  = 16'd11;
  localparam logic [MDB_W-1:0] RAIL_GAIN = 16'd5;

  // Register reset values
  localparam logic [VREF_W-1:0] VREF_RST = 13'd3300;
  localparam logic [FS_W-1:0]   FS_RST   = 16'd4096;
  localparam logic [SUP_W-1:0]  SUP_RST  = 13'd3300;
  localparam logic [SER_W-1:0]  SER_RST  = 16'd10000;

  // Channel codes
  localparam logic [CMD_W-1:0] CH_TEMP  = 3'd0;
  localparam logic [CMD_W-1:0] CH_MOTOR = 3'd1;
  localparam logic [CMD_W-1:0] CH_VALVE = 3'd2;
  localparam logic [CMD_W-1:0] CH_VIN   = 3'd3;
  localparam logic [CMD_W-1:0] CH_RAIL  = 3'd4;

  typedef enum logic [1:0] {
    CFG_VREF   = 2'd0,
    CFG_FS     = 2'd1,
    CFG_SUPPLY = 2'd2,
    CFG_SERIES = 2'd3
  } cfg_reg_t;

  typedef logic [MD_W-1:0] md_word_t;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic             start;
    md_op_t           op;
    md_word_t         opa;     // left-aligned multiplier or dividend
    logic [MDB_W-1:0] opb;     // multiplicand or divisor
    logic [DIG_W-1:0] digits;
  } md_req_t;

  typedef struct packed {
    logic     busy;
    logic     done;
    md_word_t res;
  } md_rsp_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] key;
  } sr_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } sr_rsp_t;

  // Thermistor resistance in ohms, descending with temperature index
  localparam logic [VAL_W-1:0] NTC_OHMS [TABLE_ENTRIES] = '{
    16'd28217, 16'd26988, 16'd25819, 16'd24707, 16'd23650, 16'd22643, 16'd21686,
    16'd20774, 16'd19905, 16'd19078, 16'd18290, 16'd17539, 16'd16822, 16'd16139,
    16'd15488, 16'd14867, 16'd14273, 16'd13707, 16'd13167, 16'd12650, 16'd12157,
    16'd11686, 16'd11236, 16'd10805, 16'd10394, 16'd10000, 16'd9623,  16'd9263,
    16'd8918,  16'd8588,  16'd8272,  16'd7969,  16'd7679,  16'd7401,  16'd7135,
    16'd6879,  16'd6634,  16'd6400,  16'd6174,  16'd5958,  16'd5751,  16'd5552,
    16'd5361,  16'd5177,  16'd5001,  16'd4832,  16'd4669,  16'd4513,  16'd4363,
    16'd4218,  16'd4079,  16'd3946,  16'd3817,  16'd3694,  16'd3575,  16'd3460,
    16'd3350,  16'd3244,  16'd3141,  16'd3043,  16'd2948,  16'd2856,  16'd2768,
    16'd2683,  16'd2601,  16'd2522,  16'd2446,  16'd2373,  16'd2302,  16'd2233,
    16'd2167,  16'd2103,  16'd2042,  16'd1982,  16'd1925,  16'd1870,  16'd1816,
    16'd1764,  16'd1714,  16'd1666,  16'd1619,  16'd1574,  16'd1530,  16'd1488,
    16'd1447,  16'd1407,  16'd1369,  16'd1332,  16'd1296,  16'd1261,  16'd1228,
    16'd1195,  16'd1163,  16'd1133,  16'd1103,  16'd1074,  16'd1047,  16'd1020,
    16'd994,   16'd968,   16'd944,   16'd920,   16'd897,   16'd874,   16'd853,
    16'd831,   16'd811,   16'd791,   16'd772,   16'd753,   16'd735,   16'd717,
    16'd700,   16'd683,   16'd667,   16'd651,   16'd636,   16'd621,   16'd607,
    16'd593,   16'd579,   16'd566,   16'd553,   16'd540,   16'd528,   16'd516,
    16'd505,   16'd494,   16'd483,   16'd472,   16'd462,   16'd452,   16'd442,
    16'd432,   16'd423,   16'd414,   16'd405,   16'd396,   16'd388,   16'd380,
    16'd372,   16'd364,   16'd356,   16'd349,   16'd342,   16'd335,   16'd328,
    16'd321,   16'd315,   16'd309,   16'd302
  };

endpackage

`default_nettype wire

// ===== design/adcs_in_if.sv =====
// Input channel interface: channel code and raw ADC sample.
`default_nettype none

interface adcs_in_if;
  import adcs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [RAW_W-1:0] raw_sample;

  modport source (output valid, output command, output raw_sample, input ready);
  modport sink   (input valid, input command, input raw_sample, output ready);
endinterface

`default_nettype wire

// ===== design/adcs_out_if.sv =====
// Result channel interface: echoed channel code and scaled value.
`default_nettype none

interface adcs_out_if;
  import adcs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] channel;
  logic [VAL_W-1:0] value;

  modport source (output valid, output channel, output value, input ready);
  modport sink   (input valid, input channel, input value, output ready);
endinterface

`default_nettype wire

// ===== design/adc_sensor_scaler_ntc_core.sv =====
// Top level of the ADC sensor scaler: sequencer, configuration registers, output register.
//
//   channel   dir  beat payload                  handshake
//   in_if     in   command[2:0], raw_sample[11:0] valid/ready
//   out_if    out  channel[2:0], value[15:0]      valid/ready
//   cfg_*     in   cfg_index[1:0], cfg_data[15:0] cfg_we, no back-pressure
//
// One beat at a time: a serial unit (2 bits per cycle) runs raw*vref, then /full_scale,
// then a channel-dependent multiply and/or divide; temperature then runs a table search.
// Unknown channel codes report zero after the first divide. Temperature at or above
// supply skips to the search, and motor, input voltage or rail with mv past 16 bits
// saturates at once.
// Reset (synchronous, rst_n low) idles the sequencer, empties the output register and
// loads the register defaults. A stalled result holds in the output register while the
// next beat is accepted; that beat then waits at the end until the register frees.
`default_nettype none

module adc_sensor_scaler_ntc_core (
  input  logic                        clk,
  input  logic                        rst_n,
  adcs_in_if.sink                     in_if,
  adcs_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  adcs_pkg::cfg_reg_t          cfg_index,
  input  logic [adcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import adcs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL1 = 7'b0000010,   // raw * vref
    S_DIV1 = 7'b0000100,   // / full scale -> mv
    S_MUL2 = 7'b0001000,   // channel multiply
    S_DIV2 = 7'b0010000,   // channel divide
    S_SRCH = 7'b0100000,   // NTC table search
    S_OUT  = 7'b1000000    // wait for the output register
  } state_t;

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [MV_W-1:0]   mv_r, mv_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CMD_W-1:0]  out_chan_r, out_chan_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;

  logic [VREF_W-1:0] vref_r;
  logic [FS_W-1:0]   fs_r;
  logic [SUP_W-1:0]  sup_r;
  logic [SER_W-1:0]  ser_r;

  md_req_t md_req;
  md_rsp_t md_rsp;
  sr_req_t sr_req;
  sr_rsp_t sr_rsp;

  logic [MV_W-1:0]  mv_now;
  logic             mv_fits;
  logic             sup_le;
  logic [FS_W-1:0]  fs_eff;
  logic [MDB_W-1:0] gain;

  function automatic logic [VAL_W-1:0] sat16(input md_word_t v);
    return (v[MD_W-1:VAL_W] != '0) ? '1 : v[VAL_W-1:0];
  endfunction

  // Left-align an operand so the unit consumes exactly 2*digits bits
  function automatic md_word_t md_align(input md_word_t v, input int digits);
    return v << (MD_W - 2 * digits);
  endfunction

  adcs_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  adcs_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sr_req),
    .rsp   (sr_rsp)
  );

  // Millivolts straight out of the first divide
  assign mv_now  = md_rsp.res[MV_W-1:0];
  assign mv_fits = (mv_now[MV_W-1:VAL_W] == '0);
  assign sup_le  = MV_W'(sup_r) <= mv_now;
  // Zero full scale acts as one
  assign fs_eff  = (fs_r == '0) ? FS_W'(1) : fs_r;
  assign gain    = (cmd_r == CH_MOTOR) ? MOTOR_NUM :
                   (cmd_r == CH_VIN)   ? VIN_GAIN  : RAIL_GAIN;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    mv_nxt        = mv_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_chan_nxt  = out_chan_r;
    out_val_nxt   = out_val_r;
    md_req        = '0;
    sr_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          cmd_nxt       = in_if.command;
          md_req.start  = 1'b1;
          md_req.op     = MD_MUL;
          md_req.opa    = md_align(MD_W'(in_if.raw_sample), DIG_RAW);
          md_req.opb    = MDB_W'(vref_r);
          md_req.digits = DIG_W'(DIG_RAW);
          state_nxt     = S_MUL1;
        end
      end
      S_MUL1: begin
        if (md_rsp.done) begin
          md_req.start  = 1'b1;
          md_req.op     = MD_DIV;
          md_req.opa    = md_align(MD_W'(md_rsp.res[PROD1_W-1:0]), DIG_P);
          md_req.opb    = fs_eff;
          md_req.digits = DIG_W'(DIG_P);
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (md_rsp.done) begin
          mv_nxt = mv_now;
          unique case (cmd_r) inside
            CH_TEMP: begin
              if (sup_le) begin
                // divider at or above supply: resistance pegs at full scale
                sr_req.start = 1'b1;
                sr_req.key   = '1;
                state_nxt    = S_SRCH;
              end else begin
                md_req.start  = 1'b1;
                md_req.op     = MD_MUL;
                md_req.opa    = md_align(MD_W'(mv_now[VAL_W-1:0]), DIG_MV);
                md_req.opb    = ser_r;
                md_req.digits = DIG_W'(DIG_MV);
                state_nxt     = S_MUL2;
              end
            end
            CH_MOTOR, CH_VIN, CH_RAIL: begin
              if (!mv_fits) begin
                val_nxt   = '1;
                state_nxt = S_OUT;
              end else begin
                md_req.start  = 1'b1;
                md_req.op     = MD_MUL;
                md_req.opa    = md_align(MD_W'(mv_now[VAL_W-1:0]), DIG_MV);
                md_req.opb    = gain;
                md_req.digits = DIG_W'(DIG_MV);
                state_nxt     = S_MUL2;
              end
            end
            CH_VALVE: begin
              // mv*2/10 truncates the same as mv/5
              md_req.start  = 1'b1;
              md_req.op     = MD_DIV;
              md_req.opa    = md_align(MD_W'(mv_now), DIG_V);
              md_req.opb    = VALVE_DIV;
              md_req.digits = DIG_W'(DIG_V);
              state_nxt     = S_DIV2;
            end
            default: begin
              // unknown channel: report zero
              val_nxt   = '0;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_MUL2: begin
        if (md_rsp.done) begin
          if (cmd_r == CH_TEMP) begin
            md_req.start  = 1'b1;
            md_req.op     = MD_DIV;
            md_req.opa    = md_align(MD_W'(md_rsp.res[TPROD_W-1:0]), DIG_T);
            md_req.opb    = MDB_W'(sup_r - mv_r[SUP_W-1:0]);
            md_req.digits = DIG_W'(DIG_T);
            state_nxt     = S_DIV2;
          end else if (cmd_r == CH_MOTOR) begin
            md_req.start  = 1'b1;
            md_req.op     = MD_DIV;
            md_req.opa    = md_align(MD_W'(md_rsp.res[MPROD_W-1:0]), DIG_M);
            md_req.opb    = MOTOR_DEN;
            md_req.digits = DIG_W'(DIG_M);
            state_nxt     = S_DIV2;
          end else begin
            val_nxt   = sat16(md_rsp.res);
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV2: begin
        if (md_rsp.done) begin
          if (cmd_r == CH_TEMP) begin
            sr_req.start = 1'b1;
            sr_req.key   = sat16(md_rsp.res);
            state_nxt    = S_SRCH;
          end else begin
            val_nxt   = sat16(md_rsp.res);
            state_nxt = S_OUT;
          end
        end
      end
      S_SRCH: begin
        if (sr_rsp.done) begin
          val_nxt   = VAL_W'(sr_rsp.idx);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is empty or drains this cycle
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_chan_nxt  = cmd_r;
          out_val_nxt   = val_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    mv_r       <= mv_nxt;
    val_r      <= val_nxt;
    out_chan_r <= out_chan_nxt;
    out_val_r  <= out_val_nxt;
  end

  // Configuration registers: drop data bits above each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_r <= VREF_RST;
      fs_r   <= FS_RST;
      sup_r  <= SUP_RST;
      ser_r  <= SER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VREF:   vref_r <= cfg_data[VREF_W-1:0];
        CFG_FS:     fs_r   <= cfg_data[FS_W-1:0];
        CFG_SUPPLY: sup_r  <= cfg_data[SUP_W-1:0];
        CFG_SERIES: ser_r  <= cfg_data[SER_W-1:0];
        default:    vref_r <= vref_r;
      endcase
    end
  end

  assign in_if.ready    = (state_r == S_IDLE);
  assign out_if.valid   = out_valid_r;
  assign out_if.channel = out_chan_r;
  assign out_if.value   = out_val_r;

`ifndef ASSERT_OFF
  a_accept_starts_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> md_rsp.busy)
    else $error("accepted beat did not start the serial unit");

  a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |-> !md_rsp.busy)
    else $error("serial unit restarted while busy");

  a_unit_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == S_MUL1 || state_r == S_DIV1 ||
                     state_r == S_MUL2 || state_r == S_DIV2))
    else $error("serial unit finished outside an arithmetic state");

  a_search_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sr_rsp.done |-> (state_r == S_SRCH))
    else $error("table search finished outside the search state");

  a_temp_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan_r == CH_TEMP) |-> (out_val_r <= VAL_W'(LAST_IDX)))
    else $error("temperature index beyond the table");
`endif

endmodule

`default_nettype wire

// ===== design/adcs_muldiv.sv =====
// Radix-4 serial multiplier and restoring divider sharing one shift datapath.
`default_nettype none

module adcs_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  adcs_pkg::md_req_t req,
  output adcs_pkg::md_rsp_t rsp
);
  import adcs_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIG_W-1:0] cnt_r, cnt_nxt;
  md_op_t           op_r, op_nxt;
  logic [MDB_W-1:0] b_r, b_nxt;
  md_word_t         acc_r, acc_nxt;   // product, or remainder in the low bits
  md_word_t         sh_r, sh_nxt;     // multiplier, or dividend turning into quotient

  logic [MDB_W+1:0] pp;
  logic [MDB_W:0]   t1, t2;
  logic             ge1, ge2;
  logic [MDB_W-1:0] r1, r2;
  md_word_t         s1, s2;

  // Multiply digit: top two multiplier bits select 0, b, 2b or 3b
  always_comb begin
    case (sh_r[MD_W-1:MD_W-2])
      2'd0:    pp = '0;
      2'd1:    pp = {2'b00, b_r};
      2'd2:    pp = {1'b0, b_r, 1'b0};
      default: pp = {2'b00, b_r} + {1'b0, b_r, 1'b0};
    endcase
  end

  // Two restoring division steps
  always_comb begin
    t1  = {acc_r[MDB_W-1:0], sh_r[MD_W-1]};
    ge1 = t1 >= {1'b0, b_r};
    r1  = ge1 ? MDB_W'(t1 - {1'b0, b_r}) : t1[MDB_W-1:0];
    s1  = {sh_r[MD_W-2:0], ge1};
    t2  = {r1, s1[MD_W-1]};
    ge2 = t2 >= {1'b0, b_r};
    r2  = ge2 ? MDB_W'(t2 - {1'b0, b_r}) : t2[MDB_W-1:0];
    s2  = {s1[MD_W-2:0], ge2};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.digits;
      op_nxt   = req.op;
      b_nxt    = req.opb;
      acc_nxt  = '0;
      sh_nxt   = req.opa;
    end else if (busy_r) begin
      if (op_r == MD_MUL) begin
        acc_nxt = (acc_r << 2) + MD_W'(pp);
        sh_nxt  = sh_r << 2;
      end else begin
        acc_nxt = MD_W'(r2);
        sh_nxt  = s2;
      end
      cnt_nxt = cnt_r - DIG_W'(1);
      if (cnt_r == DIG_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = (op_r == MD_MUL) ? acc_r : sh_r;

endmodule

`default_nettype wire

// ===== design/adcs_search.sv =====
// Binary search of the NTC table for the first entry the resistance reaches.
`default_nettype none

module adcs_search (
  input  logic              clk,
  input  logic              rst_n,
  input  adcs_pkg::sr_req_t req,
  output adcs_pkg::sr_rsp_t rsp
);
  import adcs_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SCNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [VAL_W-1:0]  key_r, key_nxt;

  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] mid;
  logic             hit;

  // Last index always counts as a hit, so hi always holds a hit
  assign sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = sum[IDX_W:1];
  assign hit = (mid == LAST_IDX) || (key_r >= NTC_OHMS[mid]);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    key_nxt  = key_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SCNT_W'(SRCH_STEPS);
      lo_nxt   = '0;
      hi_nxt   = LAST_IDX;
      key_nxt  = req.key;
    end else if (busy_r) begin
      if (hit) begin
        hi_nxt = mid;
      end else begin
        lo_nxt = mid + IDX_W'(1);
      end
      cnt_nxt = cnt_r - SCNT_W'(1);
      if (cnt_r == SCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    key_r <= key_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.idx  = lo_r;

endmodule

`default_nettype wire
